// ===== sv/tkc_pkg.sv =====
// Package for the timer / keyboard / console peripheral.
// Holds the beat structs, opcode and offset codes and sizing constants; no dependencies.
package tkc_pkg;

  localparam int unsigned ADDR_W             = 32;
  localparam int unsigned DATA_W             = 32;
  localparam int unsigned KEY_W              = 8;
  localparam int unsigned TICK_W             = 16;
  localparam int unsigned RECIP_W            = 16;
  localparam int unsigned COUNT_W            = 64;
  localparam int unsigned USEC_SHIFT         = 16;
  localparam int unsigned RING_DEPTH_DEFAULT = 256;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_KEY_PUSH = 2'd2,
    OP_TICK     = 2'd3
  } tkc_op_e;

  localparam logic [1:0] SIZE_DWORD = 2'd2;

  // Config register indexes
  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_RECIP = 1'b1;

  localparam logic [RECIP_W-1:0] RECIP_RESET = 16'd655;

  // Register window offsets
  localparam logic [ADDR_W-1:0] OFS_TIME_LO    = 32'h0000_0000;
  localparam logic [ADDR_W-1:0] OFS_TIME_HI    = 32'h0000_0004;
  localparam logic [ADDR_W-1:0] OFS_HOOK       = 32'h0000_0008;
  localparam logic [ADDR_W-1:0] OFS_RESET      = 32'h0000_000C;
  localparam logic [ADDR_W-1:0] OFS_KEY_POP    = 32'h0000_0010;
  localparam logic [ADDR_W-1:0] OFS_CONSOLE    = 32'h0000_0014;
  localparam logic [ADDR_W-1:0] OFS_KEY_STATUS = 32'h0000_0018;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
    logic [1:0]        access_size;
    logic [DATA_W-1:0] write_data;
    logic [KEY_W-1:0]  key_code;
    logic [TICK_W-1:0] tick_cycles;
  } tkc_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              console_valid;
    logic [KEY_W-1:0]  console_char;
    logic              key_overflow;
  } tkc_out_t;

endpackage

// ===== sv/tkc_key_ram.sv =====
// Key ring storage: one write port, one registered read port, write-first on collision.
// Depends on tkc_pkg for the key width.
module tkc_key_ram
  import tkc_pkg::*;
#(
  parameter int unsigned DEPTH = RING_DEPTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [KEY_W-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [KEY_W-1:0]         rdata_o
);

  logic [KEY_W-1:0] mem_q [DEPTH];
  logic [KEY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // same-address write bypasses the array so the read sees the new key
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tkc_core.sv =====
// Execute stage: address decode, peripheral state, key ring pointers and result forming.
// Depends on tkc_pkg and tkc_key_ram.
module tkc_core
  import tkc_pkg::*;
#(
  parameter int unsigned KEY_RING_DEPTH = RING_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               exec_i,
  input  tkc_in_t            item_i,
  input  logic [ADDR_W-1:0]  base_i,
  input  logic [RECIP_W-1:0] recip_i,
  output tkc_out_t           res_o
);

  localparam int unsigned PTR_W = $clog2(KEY_RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(KEY_RING_DEPTH - 1);

  logic [COUNT_W-1:0] count_q, count_d;
  logic [DATA_W-1:0]  hook_q, hook_d;
  logic [DATA_W-1:0]  rtick_q, rtick_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;

  logic [ADDR_W-1:0]          ofs;
  logic                       is_dword;
  logic                       is_rd, is_wr, is_push, is_tick;
  logic [PTR_W-1:0]           rd_nxt, wr_nxt;
  logic                       ring_empty, ring_full;
  logic                       pop, push_ok;
  logic [KEY_W-1:0]           key_head;
  logic [COUNT_W+RECIP_W-1:0] prod;
  logic [COUNT_W-USEC_SHIFT-1:0] usec;
  logic [DATA_W-1:0]          rdata;

  assign ofs      = item_i.address - base_i;
  assign is_dword = (item_i.access_size == SIZE_DWORD);
  assign is_rd    = (item_i.opcode == OP_READ);
  assign is_wr    = (item_i.opcode == OP_WRITE);
  assign is_push  = (item_i.opcode == OP_KEY_PUSH);
  assign is_tick  = (item_i.opcode == OP_TICK);

  assign rd_nxt     = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
  assign wr_nxt     = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
  assign ring_empty = (rd_ptr_q == wr_ptr_q);
  assign ring_full  = (wr_nxt == rd_ptr_q);

  assign pop     = exec_i && is_rd && is_dword && (ofs == OFS_KEY_POP) && !ring_empty;
  assign push_ok = exec_i && is_push && !ring_full;

  // microsecond clock: (count * recip) mod 2^64, then >> 16
  assign prod = (COUNT_W+RECIP_W)'(count_q) * (COUNT_W+RECIP_W)'(recip_i);
  assign usec = prod[COUNT_W-1:USEC_SHIFT];

  always_comb begin
    rdata = '0;
    if (is_rd && is_dword) begin
      case (ofs)
        OFS_TIME_LO:    rdata = usec[DATA_W-1:0];
        OFS_TIME_HI:    rdata = DATA_W'(usec[COUNT_W-USEC_SHIFT-1:DATA_W]);
        OFS_HOOK:       rdata = hook_q;
        OFS_RESET:      rdata = rtick_q;
        OFS_KEY_POP:    rdata = ring_empty ? '0 : DATA_W'(key_head);
        OFS_KEY_STATUS: rdata = DATA_W'(!ring_empty);
        default:        rdata = '0;
      endcase
    end
  end

  always_comb begin
    res_o               = '0;
    res_o.read_data     = rdata;
    res_o.console_valid = is_wr && is_dword && (ofs == OFS_CONSOLE);
    res_o.console_char  = res_o.console_valid ? item_i.write_data[KEY_W-1:0] : '0;
    res_o.key_overflow  = is_push && ring_full;
  end

  always_comb begin
    count_d  = count_q;
    hook_d   = hook_q;
    rtick_d  = rtick_q;
    rd_ptr_d = pop ? rd_nxt : rd_ptr_q;
    wr_ptr_d = push_ok ? wr_nxt : wr_ptr_q;
    if (exec_i && is_tick) begin
      count_d = count_q + COUNT_W'(item_i.tick_cycles);
    end
    if (exec_i && is_wr && is_dword) begin
      if (ofs == OFS_HOOK) begin
        hook_d = item_i.write_data;
      end
      if (ofs == OFS_RESET) begin
        rtick_d = item_i.write_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      hook_q   <= '0;
      rtick_q  <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
    end else begin
      count_q  <= count_d;
      hook_q   <= hook_d;
      rtick_q  <= rtick_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
    end
  end

  // read port always looks at the next head, so key_head is the current head
  tkc_key_ram #(
    .DEPTH (KEY_RING_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (wr_ptr_q),
    .wdata_i (item_i.key_code),
    .raddr_i (rd_ptr_d),
    .rdata_o (key_head)
  );

`ifndef SYNTH
  a_rd_moves_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(rd_ptr_q) |-> $past(pop))
    else $error("read pointer moved without a pop");

  a_wr_moves_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_ok |=> (wr_ptr_q != $past(wr_ptr_q)))
    else $error("accepted key push did not advance write pointer");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_ptr_q <= PTR_LAST) && (wr_ptr_q <= PTR_LAST))
    else $error("ring pointer beyond ring depth");

  a_no_pop_and_push_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_i && res_o.key_overflow) |=> $stable(wr_ptr_q))
    else $error("dropped key moved write pointer");
`endif

endmodule

// ===== sv/timer_keyboard_console_mmio.sv =====
// Timer / keyboard / console peripheral top level.
// An accepted beat is held in the input register, then executed into the result register that drives out_valid_o.
// Throughput: one beat per cycle, set by the single execute stage between the
// input register and the result register; out_stall_i back-pressures directly.
// Reset: pointers, counters, tick registers and config clear (reciprocal to 655);
// the key RAM is not cleared, only pushed entries are ever popped.
module timer_keyboard_console_mmio
  import tkc_pkg::*;
#(
  parameter int unsigned KEY_RING_DEPTH = RING_DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // config write port
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tkc_in_t           in_data_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tkc_out_t          out_data_o
);

  // config registers
  logic [ADDR_W-1:0]  base_q;
  logic [RECIP_W-1:0] recip_q;

  // input register
  logic    in_v_q;
  tkc_in_t in_q;

  // result register
  logic     out_v_q;
  tkc_out_t out_q;

  logic     exec;
  logic     in_accept;
  tkc_out_t res;

  // the held beat executes whenever the result register is free or draining
  assign exec       = in_v_q && (!out_v_q || !out_stall_i);
  assign in_stall_o = in_v_q && !exec;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      recip_q <= RECIP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE:  base_q  <= cfg_wdata_i;
        CFG_RECIP: recip_q <= cfg_wdata_i[RECIP_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_accept) begin
      in_v_q <= 1'b1;
    end else if (exec) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  tkc_core #(
    .KEY_RING_DEPTH (KEY_RING_DEPTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .exec_i  (exec),
    .item_i  (in_q),
    .base_i  (base_q),
    .recip_i (recip_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (exec) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_exec_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> out_valid_o)
    else $error("executed beat did not reach the result register");

  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  a_no_exec_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !exec)
    else $error("beat executed over a stalled result");
`endif

endmodule
